>>> rtl/core/sha256_pkg.sv
// Package with SHA-256 constants, state encoding and a rotate-right function.
package sha256_pkg;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCHED = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_FOLD  = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [5:0] LENGTH_START = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> rtl/core/sha256_stream_hash_unit.sv
// Top level of the byte-serial SHA-256 hash unit.
//
// The unit takes a message one byte per item and emits the 32-bit digest words h0..h7 as
// eight result items after the item marked last. A byte that does not complete a 64-byte
// block is only written into the block buffer. A byte that completes one is followed by a state
// that loads the working variables, then 64 rounds (one shared round datapath, one round per
// cycle, the message schedule extended in a 16-word sliding window) and a fold into the hash.
// The last item then feeds the 0x80 byte, zero fill and the length field through the same
// byte path, one byte per cycle, giving one or two more compressions, and then the eight
// digest words go out one per accepted result. req_tready is low through all of this.
module sha256_stream_hash_unit #(
   parameter int LENGTH_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], has_byte[8], zeros above
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic [2:0]  rsp_tuser,   // word_index[2:0]
   output logic        rsp_tlast    // final_word
);

   sha256_pkg::state_type state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] win_ff [16];
   logic [31:0] wv_ff [8];
   logic [5:0]  fill_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic [6:0]  round_ff;
   logic        padding_ff;  // set once the length field has gone in
   logic [2:0]  emit_ff;
   // The message is being padded, the 0x80 byte is still to go, and the current block
   // is the one that carries the length field.
   logic        pad_mode_ff, pad80_ff, len_blk_ff;

   // Byte entering the block buffer this cycle.
   logic        put_en;
   logic [7:0]  put_byte;
   logic [63:0] len64;
   logic [2:0]  len_sel;
   logic        accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == sha256_pkg::ST_IDLE);
   assign len64      = 64'(len_ff);
   assign len_sel    = fill_ff[2:0];

   always_comb begin
      put_en   = 1'b0;
      put_byte = req_tdata[7:0];
      if (state_ff == sha256_pkg::ST_IDLE) begin
         put_en = accept && req_tdata[8];
      end else if (state_ff == sha256_pkg::ST_PAD) begin
         put_en = 1'b1;
         if (!padding_ff && pad80_ff) begin
            put_byte = sha256_pkg::PAD_BYTE;
         end else if (len_blk_ff && fill_ff >= sha256_pkg::LENGTH_START) begin
            put_byte = len64[(7 - len_sel) * 8 +: 8];
         end else begin
            put_byte = 8'h00;
         end
      end
   end

   // Round datapath: the window head is w[t]; the next schedule word is appended at the tail.
   logic [31:0] s0, s1, w_next, big0, big1, ch, maj, t1, t2;
   always_comb begin
      s0 = sha256_pkg::rotr(win_ff[1], 7) ^ sha256_pkg::rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      s1 = sha256_pkg::rotr(win_ff[14], 17) ^ sha256_pkg::rotr(win_ff[14], 19)
         ^ (win_ff[14] >> 10);
      w_next = s1 + win_ff[9] + s0 + win_ff[0];
      big1 = sha256_pkg::rotr(wv_ff[4], 6) ^ sha256_pkg::rotr(wv_ff[4], 11)
           ^ sha256_pkg::rotr(wv_ff[4], 25);
      ch   = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      t1   = wv_ff[7] + big1 + ch + sha256_pkg::ROUND_K[round_ff[5:0]] + win_ff[0];
      big0 = sha256_pkg::rotr(wv_ff[0], 2) ^ sha256_pkg::rotr(wv_ff[0], 13)
           ^ sha256_pkg::rotr(wv_ff[0], 22);
      maj  = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t2   = big0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (accept) begin
               if (put_en && fill_ff == 6'd63) state_in = sha256_pkg::ST_SCHED;
               else if (req_tlast)              state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_SCHED: state_in = sha256_pkg::ST_ROUND;
         sha256_pkg::ST_ROUND: if (round_ff == 7'd63) state_in = sha256_pkg::ST_FOLD;
         sha256_pkg::ST_FOLD: begin
            if (padding_ff)        state_in = sha256_pkg::ST_EMIT;
            else if (pad_mode_ff)  state_in = sha256_pkg::ST_PAD;
            else                   state_in = sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_PAD:
            if (fill_ff == 6'd63) state_in = sha256_pkg::ST_SCHED;
         sha256_pkg::ST_EMIT:
            if (rsp_tready && emit_ff == 3'd7) state_in = sha256_pkg::ST_IDLE;
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha256_pkg::ST_IDLE;
         fill_ff     <= '0;
         len_ff      <= '0;
         round_ff    <= '0;
         padding_ff  <= 1'b0;
         pad_mode_ff <= 1'b0;
         pad80_ff    <= 1'b0;
         len_blk_ff  <= 1'b0;
         emit_ff     <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::INIT_H[i];
      end else begin
         state_ff <= state_in;
         if (put_en) begin
            fill_ff <= fill_ff + 6'd1;
            if (fill_ff[1:0] == 2'd0) win_ff[fill_ff[5:2]] <= {put_byte, 24'h0};
            else win_ff[fill_ff[5:2]][(3 - fill_ff[1:0]) * 8 +: 8] <= put_byte;
            if (state_ff == sha256_pkg::ST_PAD) begin
               pad80_ff <= 1'b0;
               // A 0x80 byte ahead of byte 56 leaves room for the length in this block.
               if (pad80_ff && fill_ff < sha256_pkg::LENGTH_START) len_blk_ff <= 1'b1;
               if (fill_ff == 6'd63 && len_blk_ff) padding_ff <= 1'b1;
            end
         end
         if (accept && req_tdata[8]) len_ff <= len_ff + LENGTH_BITS'(8);
         if (accept && req_tlast) begin
            pad_mode_ff <= 1'b1;
            pad80_ff    <= 1'b1;
         end
         case (state_ff)
            sha256_pkg::ST_SCHED: begin
               for (int i = 0; i < 8; i++) wv_ff[i] <= hash_ff[i];
               round_ff <= '0;
            end
            sha256_pkg::ST_ROUND: begin
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
               win_ff[15] <= w_next;
               wv_ff[7] <= wv_ff[6];
               wv_ff[6] <= wv_ff[5];
               wv_ff[5] <= wv_ff[4];
               wv_ff[4] <= wv_ff[3] + t1;
               wv_ff[3] <= wv_ff[2];
               wv_ff[2] <= wv_ff[1];
               wv_ff[1] <= wv_ff[0];
               wv_ff[0] <= t1 + t2;
               round_ff <= round_ff + 7'd1;
            end
            sha256_pkg::ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + wv_ff[i];
               round_ff <= '0;
               emit_ff  <= '0;
               // The 0x80 byte went in too late for the length: the next block carries it.
               if (pad_mode_ff && !pad80_ff && !padding_ff) len_blk_ff <= 1'b1;
            end
            sha256_pkg::ST_EMIT: begin
               if (rsp_tready) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::INIT_H[i];
                     fill_ff     <= '0;
                     len_ff      <= '0;
                     padding_ff  <= 1'b0;
                     pad_mode_ff <= 1'b0;
                     pad80_ff    <= 1'b0;
                     len_blk_ff  <= 1'b0;
                     round_ff    <= '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == sha256_pkg::ST_EMIT);
   assign rsp_tdata  = hash_ff[emit_ff];
   assign rsp_tuser  = emit_ff;
   assign rsp_tlast  = (emit_ff == 3'd7);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha256_pkg::ST_IDLE |-> !req_tready)
      else $error("input accepted while busy");
   a_rounds_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256_pkg::ST_ROUND |-> round_ff < 7'd64)
      else $error("round counter out of range");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1)
      else $error("digest words out of order");

endmodule

>>> bench/sha256_stream_hash_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the byte-serial SHA-256 unit: self-predicting message digests.
module sha256_stream_hash_unit_tb;

   // One input item: a message byte, a flag that says it carries one, and the end mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } msg_item_type;

   // One digest word as the unit should emit it.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   sha256_stream_hash_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   msg_item_type    pending_items[$];
   digest_item_type expected_digests[$];
   int              error_count = 0;
   int              messages_hashed = 0;
   int              words_checked = 0;

   // Flow control knobs that the stimulus process adjusts per phase.
   bit  idle_enable = 1;
   bit  sender_pause = 0;
   bit  long_holdoff_request = 0;
   int  holdoff_left = 0;
   // Set at a rising edge that took the offered item.
   bit  req_accepted = 0;

   // Predictor state: running hash, current block, fill level and bit count.
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   int unsigned block_fill;
   logic [63:0] message_bits;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over the current block and fold into the running hash.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_w[i];
      for (int i = 16; i < 64; i++) begin
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      end
      {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                  chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int r = 0; r < 64; r++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + sha256_pkg::ROUND_K[r] + w[r];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic absorb_byte(logic [7:0] value);
      int sh;
      sh = (3 - (block_fill % 4)) * 8;
      if (block_fill % 4 == 0) block_w[block_fill / 4] = 32'h0;
      block_w[block_fill / 4] |= 32'(value) << sh;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_h[i] = sha256_pkg::INIT_H[i];
      block_fill = 0;
      message_bits = 0;
   endtask

   // Predict the digest words caused by one accepted item.
   task automatic predict_digest(msg_item_type it);
      digest_item_type d;
      if (it.has_byte) begin
         absorb_byte(it.data_byte);
         message_bits += 64'd8;
      end
      if (!it.last_byte) return;
      absorb_byte(sha256_pkg::PAD_BYTE);
      while (block_fill != sha256_pkg::LENGTH_START) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(message_bits[(7-i)*8 +: 8]);
      for (int i = 0; i < 8; i++) begin
         d.digest_word = chain_h[i];
         d.word_index  = 3'(i);
         d.final_word  = (i == 7);
         expected_digests.push_back(d);
      end
      messages_hashed++;
      restart_message();
   endtask

   // Driver: offers the head of the queue, changes inputs on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_accepted) begin
         // Hold the offered item until it is taken.
      end else if (pending_items.size() > 0 && !sender_pause &&
                   !(idle_enable && $urandom_range(99) < 34)) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {7'b0, pending_items[0].has_byte, pending_items[0].data_byte};
         req_tlast  <= pending_items[0].last_byte;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Accepted items go to the predictor and leave the pending queue.
   always @(posedge clock) begin
      msg_item_type it;
      req_accepted = !reset && req_tvalid && req_tready;
      if (req_accepted) begin
         it.data_byte = req_tdata[7:0];
         it.has_byte  = req_tdata[8];
         it.last_byte = req_tlast;
         predict_digest(it);
         void'(pending_items.pop_front());
      end
   end

   // Receiver backpressure, with a long hold-off counted here on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_holdoff_request && holdoff_left == 0) begin
         holdoff_left = 400;
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_tready <= (holdoff_left == 0);
      end else begin
         rsp_tready <= !(idle_enable && $urandom_range(99) < 34);
      end
   end

   // Monitor: each accepted digest word is checked against the oldest expectation.
   always @(posedge clock) begin
      digest_item_type exp_d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest word %h", rsp_tdata);
            error_count++;
         end else begin
            exp_d = expected_digests.pop_front();
            words_checked++;
            if (rsp_tdata !== exp_d.digest_word) begin
               $error("digest_word: expected %h, got %h", exp_d.digest_word, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_d.word_index) begin
               $error("word_index: expected %0d, got %0d", exp_d.word_index, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== exp_d.final_word) begin
               $error("final_word: expected %0d, got %0d", exp_d.final_word, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   task automatic queue_item(logic [7:0] value, logic has, logic last);
      msg_item_type it;
      it.data_byte = value;
      it.has_byte  = has;
      it.last_byte = last;
      pending_items.push_back(it);
   endtask

   // A whole message of random bytes, sometimes closed by a byte-less last item.
   task automatic queue_message(int length);
      bit empty_close;
      empty_close = ($urandom_range(3) == 0) || (length == 0);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(15) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
         queue_item(8'($urandom), 1'b1, (i == length - 1) && !empty_close);
      end
      if (empty_close) queue_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_digests.size() > 0) @(posedge clock);
   endtask

   initial begin
      int lengths [] = '{55, 56, 63, 64};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 16'h0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      restart_message();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the empty message, a lone ignored item, and the three-byte "abc".
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      // Extreme byte values, ended by a last item with no byte, then a lone 0xff message.
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'hff, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hff, 1'b1, 1'b1);
      wait_drained();

      // Sender pause: the queued message is not offered until the pause is lifted.
      sender_pause = 1;
      queue_message(3);
      repeat (20) @(posedge clock);
      sender_pause = 0;
      wait_drained();

      // Padding boundaries: one or two extra blocks at the length field.
      foreach (lengths[i]) queue_message(lengths[i]);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering short messages.
      long_holdoff_request = 1;
      @(posedge clock);
      long_holdoff_request = 0;
      for (int i = 0; i < 4; i++) queue_message($urandom_range(1, 6));
      wait_drained();

      // Random short messages; the first stretch runs without idling.
      idle_enable = 0;
      for (int i = 0; i < 6; i++) queue_message($urandom_range(0, 8));
      wait_drained();
      idle_enable = 1;
      for (int i = 0; i < 8; i++) queue_message($urandom_range(0, 12));
      wait_drained();
      repeat (200) @(posedge clock);

      $display("Hashed %0d messages, %0d digest words checked, incl. empty and padding edges.",
               messages_hashed, words_checked);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
